### src/obb_pkg.sv
// Shared constants for the oriented box overlap tester.
package obb_pkg;
  localparam int unsigned CoordWidthDef   = 16;
  localparam int unsigned AxisFracBitsDef = 14;
  localparam int unsigned EpsWidth        = 8;
  localparam logic [EpsWidth-1:0] EpsReset = 8'd1;
  localparam int unsigned CfgIdxWidth     = 3;
  localparam logic [CfgIdxWidth-1:0] RegRefCenter = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegRefHalf   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegRefRow0   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegRefRow1   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegRefRow2   = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegEpsilon   = 3'd5;
endpackage

### src/obb_core.sv
// Pipelined separating-axis arithmetic: rotation, offset, radii, compare.
module obb_core #(
  parameter int unsigned CW = obb_pkg::CoordWidthDef,
  parameter int unsigned FB = obb_pkg::AxisFracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [3*CW-1:0]      a_center_i,
  input  logic [3*CW-1:0]      a_half_i,
  input  logic [3*(FB+2)-1:0]  a_row_i [3],
  input  logic [obb_pkg::EpsWidth-1:0] eps_i,
  input  logic [3*CW-1:0]      b_center_i,
  input  logic [3*(CW-1)-1:0]  b_half_i,
  input  logic [3*(FB+2)-1:0]  b_row_i [3],
  output logic                 valid_o,
  output logic                 overlap_o
);
  import obb_pkg::*;
  localparam int unsigned AW = FB + 2;
  localparam int unsigned DW = CW + 1;            // center difference
  localparam int unsigned PW = AW + DW + 2;       // dot sums
  localparam int unsigned TW = PW - FB;           // t after shift
  localparam int unsigned RW = 2 * AW + 2 - FB;   // r after shift
  localparam int unsigned MW = RW + 1;            // |r| + eps
  localparam int unsigned XW = TW + RW + 3;       // distance sums
  localparam int unsigned HW = CW + 1;            // half extent, unsigned + sign
  localparam int unsigned QW = HW + MW + 3;       // radius sums
  localparam int unsigned CWD = (XW > QW ? XW : QW) + FB + 2;

  // stage 1: unpack, center offset, rotation products
  logic signed [AW-1:0] ar [3][3];
  logic signed [AW-1:0] br [3][3];
  logic signed [DW-1:0] dc [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        ar[i][k] = a_row_i[i][k*AW +: AW];
        br[i][k] = b_row_i[i][k*AW +: AW];
      end
      dc[i] = DW'($signed(b_center_i[i*CW +: CW])) - DW'($signed(a_center_i[i*CW +: CW]));
    end
  end

  logic signed [PW-1:0] t1_q [3];
  logic signed [2*AW+1:0] r1_q [3][3];
  logic [HW-1:0] ha1_q [3], hb1_q [3];
  logic [EpsWidth-1:0] eps1_q;
  logic v1_q, v2_q, v3_q, v4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      eps1_q <= eps_i;
      for (int i = 0; i < 3; i++) begin
        ha1_q[i] <= HW'(a_half_i[i*CW +: CW]);
        hb1_q[i] <= HW'(b_half_i[i*(CW-1) +: (CW-1)]);
        t1_q[i] <= PW'(ar[i][0] * dc[0]) + PW'(ar[i][1] * dc[1]) + PW'(ar[i][2] * dc[2]);
        for (int j = 0; j < 3; j++)
          r1_q[i][j] <= (2*AW+2)'(ar[i][0] * br[j][0]) + (2*AW+2)'(ar[i][1] * br[j][1])
                      + (2*AW+2)'(ar[i][2] * br[j][2]);
      end
    end
  end

  // stage 2: floor shift, magnitudes
  logic signed [TW-1:0] t2_q [3];
  logic signed [RW-1:0] r2_q [3][3];
  logic [MW-1:0] m2_q [3][3];
  logic [HW-1:0] ha2_q [3], hb2_q [3];
  logic signed [RW-1:0] rs [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) rs[i][j] = RW'(r1_q[i][j] >>> FB);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        ha2_q[i] <= ha1_q[i];
        hb2_q[i] <= hb1_q[i];
        t2_q[i] <= TW'(t1_q[i] >>> FB);
        for (int j = 0; j < 3; j++) begin
          r2_q[i][j] <= rs[i][j];
          m2_q[i][j] <= (rs[i][j][RW-1] ? MW'(-rs[i][j]) : MW'(rs[i][j])) + MW'(eps1_q);
        end
      end
    end
  end

  // stage 3: products for every axis
  logic signed [XW-1:0] tr3_q [3][3];   // t[k]*r[k][j]
  logic signed [XW-1:0] tx3_q [3][3][2];
  logic [QW-1:0] pa3_q [3][3];          // ha[i]*m[i][j]
  logic [QW-1:0] pb3_q [3][3];          // hb[j]*m[i][j]
  logic [QW-1:0] qa3_q [3][3][2];       // ha[i+1]*m[i+2][j], ha[i+2]*m[i+1][j]
  logic [QW-1:0] qb3_q [3][3][2];       // hb[j+1]*m[i][j+2], hb[j+2]*m[i][j+1]
  logic signed [TW-1:0] t3_q [3];
  logic [HW-1:0] ha3_q [3], hb3_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        t3_q[i] <= t2_q[i];
        ha3_q[i] <= ha2_q[i];
        hb3_q[i] <= hb2_q[i];
        for (int j = 0; j < 3; j++) begin
          tr3_q[i][j] <= XW'(t2_q[i] * r2_q[i][j]);
          pa3_q[i][j] <= QW'(ha2_q[i] * m2_q[i][j]);
          pb3_q[i][j] <= QW'(hb2_q[j] * m2_q[i][j]);
          qa3_q[i][j][0] <= QW'(ha2_q[(i+1)%3] * m2_q[(i+2)%3][j]);
          qa3_q[i][j][1] <= QW'(ha2_q[(i+2)%3] * m2_q[(i+1)%3][j]);
          qb3_q[i][j][0] <= QW'(hb2_q[(j+1)%3] * m2_q[i][(j+2)%3]);
          qb3_q[i][j][1] <= QW'(hb2_q[(j+2)%3] * m2_q[i][(j+1)%3]);
          tx3_q[i][j][0] <= XW'(t2_q[(i+2)%3] * r2_q[(i+1)%3][j]);
          tx3_q[i][j][1] <= XW'(t2_q[(i+1)%3] * r2_q[(i+2)%3][j]);
        end
      end
    end
  end

  // stage 4: sums and compares
  logic [14:0] sep_d;
  logic [14:0] sep4_q;
  logic flat;
  logic signed [CWD-1:0] proj, rad;
  always_comb begin
    flat = (ha3_q[2] == '0) && (hb3_q[2] == '0);
    for (int i = 0; i < 3; i++) begin
      proj = CWD'(t3_q[i]) <<< FB;
      if (proj < 0) proj = -proj;
      rad = (CWD'(ha3_q[i]) << FB) + CWD'(pb3_q[i][0]) + CWD'(pb3_q[i][1])
          + CWD'(pb3_q[i][2]);
      sep_d[i] = (proj > rad) && !(flat && i == 2);
      proj = CWD'(tr3_q[0][i]) + CWD'(tr3_q[1][i]) + CWD'(tr3_q[2][i]);
      if (proj < 0) proj = -proj;
      rad = (CWD'(hb3_q[i]) << FB) + CWD'(pa3_q[0][i]) + CWD'(pa3_q[1][i])
          + CWD'(pa3_q[2][i]);
      sep_d[3+i] = (proj > rad) && !(flat && i == 2);
      for (int j = 0; j < 3; j++) begin
        proj = CWD'(tx3_q[i][j][0]) - CWD'(tx3_q[i][j][1]);
        if (proj < 0) proj = -proj;
        rad = CWD'(qa3_q[i][j][0]) + CWD'(qa3_q[i][j][1])
            + CWD'(qb3_q[i][j][0]) + CWD'(qb3_q[i][j][1]);
        sep_d[6+3*i+j] = proj > rad;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) sep4_q <= sep_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  assign valid_o   = v4_q;
  assign overlap_o = ~|sep4_q;
endmodule

### src/obb_separating_axis_test.sv
// Top level of the oriented box overlap tester.
//  channel | dir | content
//  s_axis  | in  | tested box: centers, half extents, orientation rows
//  m_axis  | out | overlap flag
//  cfg     | in  | reference box and epsilon writes
// One box per cycle while the output is not stalled; each accepted request
// passes through the four-stage arithmetic pipeline (dots, shift, products, sums).
// Reset clears the valid bits and loads register defaults.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module obb_separating_axis_test #(
  parameter int unsigned COORD_WIDTH    = obb_pkg::CoordWidthDef,
  parameter int unsigned AXIS_FRAC_BITS = obb_pkg::AxisFracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // center x,y,z (signed); half x,y,z; axis row0,row1,row2; zero fill
  input  logic [((6*COORD_WIDTH-3+9*(AXIS_FRAC_BITS+2))+7)/8*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // overlap; zero fill
  output logic [7:0] m_axis_tdata,
  input  logic cfg_we_i,
  input  logic [obb_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [3*(COORD_WIDTH > AXIS_FRAC_BITS+2 ? COORD_WIDTH : AXIS_FRAC_BITS+2)-1:0]
               cfg_data_i
);
  import obb_pkg::*;
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned AW = AXIS_FRAC_BITS + 2;
  localparam int unsigned HO = 3 * CW;
  localparam int unsigned RO = HO + 3 * (CW - 1);

  logic [3*CW-1:0] ctr_q, half_q;
  logic [3*AW-1:0] row_q [3];
  logic [EpsWidth-1:0] eps_q;
  logic [3*AW-1:0] brow [3];
  logic en, cv, cov;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0; half_q <= '0; row_q[0] <= '0; row_q[1] <= '0; row_q[2] <= '0;
      eps_q <= EpsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRefCenter: ctr_q <= cfg_data_i[3*CW-1:0];
        RegRefHalf:   half_q <= cfg_data_i[3*CW-1:0];
        RegRefRow0:   row_q[0] <= cfg_data_i[3*AW-1:0];
        RegRefRow1:   row_q[1] <= cfg_data_i[3*AW-1:0];
        RegRefRow2:   row_q[2] <= cfg_data_i[3*AW-1:0];
        RegEpsilon:   eps_q <= cfg_data_i[EpsWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) brow[i] = s_axis_tdata[RO + i*3*AW +: 3*AW];
  end

  // advance whenever the output slot is empty or being drained
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  obb_core #(.CW(CW), .FB(AXIS_FRAC_BITS)) u_core (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid),
    .a_center_i(ctr_q), .a_half_i(half_q), .a_row_i(row_q), .eps_i(eps_q),
    .b_center_i(s_axis_tdata[HO-1:0]), .b_half_i(s_axis_tdata[RO-1:HO]),
    .b_row_i(brow), .valid_o(cv), .overlap_o(cov)
  );

  assign m_axis_tvalid = cv;
  assign m_axis_tdata  = {7'd0, cov};
endmodule

### src/obb_checker.sv
// Port-level checks for the oriented box overlap tester.
module obb_port_props (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while pipeline frozen");
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("idle output blocks requests");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("result fill bits set");
endmodule

bind obb_separating_axis_test obb_port_props u_chk (.*);
